[rtl/rlbe_pkg.sv]
package rlbe_pkg;

    // Longest run or literal group before it is closed.
    localparam int MAX_RUN   = 32;
    // A run of two may take a third byte before it closes, so one spare entry.
    localparam int BUF_DEPTH = MAX_RUN + 1;
    localparam int ADDR_W    = $clog2(BUF_DEPTH);
    localparam int CNT_W     = $clog2(BUF_DEPTH + 1);
    localparam int BYTE_W    = 8;

    // A literal control byte is this base plus the number of literal bytes.
    localparam logic [BYTE_W-1:0] LIT_BASE = 8'd127;

    typedef logic [BYTE_W-1:0] t_byte;
    typedef logic [CNT_W-1:0]  t_count;
    typedef logic [ADDR_W-1:0] t_addr;

    typedef struct packed {
        logic  wr_en;
        t_addr wr_addr;
        t_byte wr_data;
        logic  rd_en;
        t_addr rd_addr;
    } t_ram_req;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_CTRL,
        ST_LIT,
        ST_DATA
    } t_state;

endpackage

[rtl/run_length_byte_encoder.sv]
// Channel   Direction  Handshake            Payload
// input     in         i_valid / o_stall    i_data_byte, i_final_byte
// output    out        o_valid / i_stall    o_out_byte, o_is_control,
//                                           o_last_of_item, o_stream_done
//
// An input byte is accepted, then decided on; each output byte that it produces
// is then loaded from a sequencer state (control, then literal or data bytes).
// This is set by the single output register and the one read port of the run
// buffer memory, which delivers one literal byte per cycle unless the output stalls.
// Reset (synchronous, active low) clears the fill count, the repeat flag, the
// sequencer and the output valid; the buffer memory is not cleared.
// An output stall only holds the sequencer; o_stall is high while an input byte
// is still being encoded, and the final output byte may wait in the output
// register while the next input transfer is taken.

module run_length_byte_encoder (
    input  logic       i_clk,
    input  logic       i_rst_n,

    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_data_byte,
    input  logic       i_final_byte,

    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_out_byte,
    output logic       o_is_control,
    output logic       o_last_of_item,
    output logic       o_stream_done
);

    // Sequencer and stream state.
    rlbe_pkg::t_state   r_state, n_state;
    rlbe_pkg::t_count   r_fill;
    logic               r_rep;

    // The newest byte and the one before it. While a run is held, every
    // buffered byte equals these, so runs never need a memory read.
    rlbe_pkg::t_byte    r_last, r_prev;
    logic               r_fin;

    // Up to two output groups per input byte: the one closed by the new byte,
    // then the end-of-stream flush. Each is a control byte followed by either
    // one data byte or a literal stretch read from the buffer starting at 0.
    logic               r_g1_lit, r_g2_on, r_g2_lit;
    rlbe_pkg::t_byte    r_g1_ctrl, r_g2_ctrl;
    rlbe_pkg::t_count   r_g1_len, r_g2_len;
    logic               r_grp, n_grp;
    rlbe_pkg::t_count   r_idx, n_idx;

    // Output register.
    logic               r_out_valid, n_out_valid;
    rlbe_pkg::t_byte    r_out_byte, n_out_byte;
    logic               r_out_ctrl, n_out_ctrl;
    logic               r_out_last, n_out_last;
    logic               r_out_done, n_out_done;
    logic               out_load, out_free;

    // Decision made in the decide cycle.
    logic               p_eq, p_full, p_rep, p_fix;
    rlbe_pkg::t_count   p_fill;
    logic               p_g1_on, p_g1_lit, p_g2_on, p_g2_lit;
    rlbe_pkg::t_byte    p_g1_ctrl, p_g2_ctrl;
    rlbe_pkg::t_count   p_g1_len, p_g2_len;

    logic               take_in;
    logic               cur_lit, final_grp, lit_end;
    rlbe_pkg::t_byte    cur_ctrl, cur_data;
    rlbe_pkg::t_count   cur_len;

    rlbe_pkg::t_ram_req ram_req;
    rlbe_pkg::t_byte    ram_rd_data;

    rlbe_buf_ram u_buf (
        .i_clk     (i_clk),
        .i_req     (ram_req),
        .o_rd_data (ram_rd_data)
    );

    assign o_stall  = (r_state != rlbe_pkg::ST_IDLE);
    assign take_in  = i_valid && !o_stall;
    assign out_free = !r_out_valid || !i_stall;

    assign cur_lit   = r_grp ? r_g2_lit  : r_g1_lit;
    assign cur_ctrl  = r_grp ? r_g2_ctrl : r_g1_ctrl;
    assign cur_len   = r_grp ? r_g2_len  : r_g1_len;
    // A closed run carries the older byte; a flushed run carries the newest.
    assign cur_data  = r_grp ? r_last    : r_prev;
    assign final_grp = r_grp || !r_g2_on;
    assign lit_end   = ((r_idx + rlbe_pkg::t_count'(1)) == cur_len);

    // Encoding decision. At this point r_fill already counts the new byte.
    always_comb begin
        p_eq      = (r_last == r_prev);
        p_full    = (r_fill >= rlbe_pkg::t_count'(rlbe_pkg::MAX_RUN));
        p_fill    = r_fill;
        p_rep     = r_rep;
        p_fix     = 1'b0;
        p_g1_on   = 1'b0;
        p_g1_lit  = 1'b0;
        p_g1_ctrl = '0;
        p_g1_len  = '0;
        p_g2_on   = 1'b0;
        p_g2_lit  = 1'b0;
        p_g2_ctrl = '0;
        p_g2_len  = '0;

        if (r_fill >= rlbe_pkg::t_count'(2)) begin
            if (r_rep) begin
                // A run ends when the new byte differs or the run is full. The
                // new byte becomes the sole buffered byte.
                if (!p_eq || p_full) begin
                    p_g1_on   = 1'b1;
                    p_g1_ctrl = rlbe_pkg::BYTE_W'(r_fill - rlbe_pkg::t_count'(1));
                    p_fill    = rlbe_pkg::t_count'(1);
                    p_rep     = 1'b0;
                    p_fix     = 1'b1;
                end
            end else if (p_eq) begin
                // Two equal bytes start a run; whatever came before them goes
                // out as literals. The buffer head is not rewritten here since
                // a run is always emitted from the byte registers.
                p_rep = 1'b1;
                if (r_fill > rlbe_pkg::t_count'(2)) begin
                    p_g1_on   = 1'b1;
                    p_g1_lit  = 1'b1;
                    p_g1_len  = r_fill - rlbe_pkg::t_count'(2);
                    p_g1_ctrl = rlbe_pkg::LIT_BASE
                              + rlbe_pkg::BYTE_W'(r_fill - rlbe_pkg::t_count'(2));
                    p_fill    = rlbe_pkg::t_count'(2);
                end
            end else if (p_full) begin
                // A full buffer of literals goes out whole.
                p_g1_on   = 1'b1;
                p_g1_lit  = 1'b1;
                p_g1_len  = r_fill;
                p_g1_ctrl = rlbe_pkg::LIT_BASE + rlbe_pkg::BYTE_W'(r_fill);
                p_fill    = '0;
            end
        end

        if (r_fin) begin
            if (p_fill != '0) begin
                p_g2_on = 1'b1;
                if (p_rep) begin
                    p_g2_ctrl = rlbe_pkg::BYTE_W'(p_fill);
                end else begin
                    p_g2_lit  = 1'b1;
                    p_g2_len  = p_fill;
                    p_g2_ctrl = rlbe_pkg::LIT_BASE + rlbe_pkg::BYTE_W'(p_fill);
                end
            end
            p_fill = '0;
            p_rep  = 1'b0;
        end
    end

    // Sequencer: next state, buffer accesses and output register loads.
    always_comb begin
        n_state         = r_state;
        n_grp           = r_grp;
        n_idx           = r_idx;
        out_load        = 1'b0;
        n_out_byte      = r_out_byte;
        n_out_ctrl      = r_out_ctrl;
        n_out_last      = r_out_last;
        n_out_done      = r_out_done;
        ram_req.wr_en   = 1'b0;
        ram_req.wr_addr = r_fill[rlbe_pkg::ADDR_W-1:0];
        ram_req.wr_data = i_data_byte;
        ram_req.rd_en   = 1'b0;
        ram_req.rd_addr = '0;

        case (r_state)
            rlbe_pkg::ST_IDLE: begin
                if (take_in) begin
                    ram_req.wr_en = 1'b1;
                    n_state       = rlbe_pkg::ST_DECIDE;
                end
            end

            rlbe_pkg::ST_DECIDE: begin
                // When a run closes, the new byte moves to the buffer head.
                ram_req.wr_en   = p_fix;
                ram_req.wr_addr = '0;
                ram_req.wr_data = r_last;
                if (p_g1_on) begin
                    n_grp   = 1'b0;
                    n_state = rlbe_pkg::ST_CTRL;
                end else if (p_g2_on) begin
                    n_grp   = 1'b1;
                    n_state = rlbe_pkg::ST_CTRL;
                end else begin
                    n_state = rlbe_pkg::ST_IDLE;
                end
            end

            rlbe_pkg::ST_CTRL: begin
                // Prefetch the first literal while the control byte waits.
                ram_req.rd_en = 1'b1;
                if (out_free) begin
                    out_load   = 1'b1;
                    n_out_byte = cur_ctrl;
                    n_out_ctrl = 1'b1;
                    n_out_last = 1'b0;
                    n_out_done = 1'b0;
                    n_idx      = '0;
                    n_state    = cur_lit ? rlbe_pkg::ST_LIT : rlbe_pkg::ST_DATA;
                end
            end

            rlbe_pkg::ST_LIT: begin
                if (out_free) begin
                    out_load        = 1'b1;
                    n_out_byte      = ram_rd_data;
                    n_out_ctrl      = 1'b0;
                    n_out_last      = lit_end && final_grp;
                    n_out_done      = lit_end && final_grp && r_fin;
                    n_idx           = r_idx + rlbe_pkg::t_count'(1);
                    ram_req.rd_en   = !lit_end;
                    ram_req.rd_addr = rlbe_pkg::ADDR_W'(r_idx + rlbe_pkg::t_count'(1));
                    if (lit_end) begin
                        n_grp   = 1'b1;
                        n_state = final_grp ? rlbe_pkg::ST_IDLE : rlbe_pkg::ST_CTRL;
                    end
                end
            end

            rlbe_pkg::ST_DATA: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    n_out_byte = cur_data;
                    n_out_ctrl = 1'b0;
                    n_out_last = final_grp;
                    n_out_done = final_grp && r_fin;
                    n_grp      = 1'b1;
                    n_state    = final_grp ? rlbe_pkg::ST_IDLE : rlbe_pkg::ST_CTRL;
                end
            end

            default: begin
                n_state = rlbe_pkg::ST_IDLE;
            end
        endcase

        n_out_valid = out_load || (r_out_valid && i_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rlbe_pkg::ST_IDLE;
            r_fill      <= '0;
            r_rep       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (take_in) begin
                r_fill <= r_fill + rlbe_pkg::t_count'(1);
            end else if (r_state == rlbe_pkg::ST_DECIDE) begin
                r_fill <= p_fill;
                r_rep  <= p_rep;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_in) begin
            r_last <= i_data_byte;
            r_prev <= r_last;
            r_fin  <= i_final_byte;
        end
        if (r_state == rlbe_pkg::ST_DECIDE) begin
            r_g1_lit  <= p_g1_lit;
            r_g1_ctrl <= p_g1_ctrl;
            r_g1_len  <= p_g1_len;
            r_g2_on   <= p_g2_on;
            r_g2_lit  <= p_g2_lit;
            r_g2_ctrl <= p_g2_ctrl;
            r_g2_len  <= p_g2_len;
        end
        r_grp <= n_grp;
        r_idx <= n_idx;
        if (out_load) begin
            r_out_byte <= n_out_byte;
            r_out_ctrl <= n_out_ctrl;
            r_out_last <= n_out_last;
            r_out_done <= n_out_done;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_out_byte     = r_out_byte;
    assign o_is_control   = r_out_ctrl;
    assign o_last_of_item = r_out_last;
    assign o_stream_done  = r_out_done;

    // Every accepted byte is followed by exactly one decide cycle.
    a_take_then_decide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take_in |=> (r_state == rlbe_pkg::ST_DECIDE))
        else $error("accepted byte not followed by decide cycle");

    // Between items the buffer never holds more than a full group.
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rlbe_pkg::ST_IDLE)
            |-> (r_fill <= rlbe_pkg::t_count'(rlbe_pkg::MAX_RUN)))
        else $error("run buffer fill count out of range");

    // The literal read index stays inside the group being sent.
    a_lit_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rlbe_pkg::ST_LIT) |-> (r_idx < cur_len))
        else $error("literal index beyond group length");

    // End of stream is only flagged on the last byte of an item.
    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_stream_done) |-> o_last_of_item)
        else $error("stream end without last-of-item");

endmodule

[rtl/rlbe_buf_ram.sv]
module rlbe_buf_ram (
    input  logic                i_clk,
    input  rlbe_pkg::t_ram_req  i_req,
    output rlbe_pkg::t_byte     o_rd_data
);

    rlbe_pkg::t_byte r_mem [rlbe_pkg::BUF_DEPTH];
    rlbe_pkg::t_byte r_rd_data;

    // Read data is registered and holds while no read is issued.
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[sim/tb.sv]
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Length of the random part, counted in input transfers.
    localparam int RAND_ITEMS  = 90;
    // From this transfer on, neither side idles any more.
    localparam int CALM_AFTER  = 75;
    // The receiver holds off once for this many cycles after this many results.
    localparam int LONG_HOLD   = 150;
    localparam int HOLD_AT     = 50;
    // Cycles with no transfer on either channel before the run is abandoned.
    localparam int IDLE_LIMIT  = 1000;
    // Quiet cycles after the last expected byte, to catch stray output.
    localparam int TAIL_CYCLES = 40;
    // Marks a directed row whose expected bytes come from the predictor.
    localparam int PREDICTED   = -1;

    // One encoded output byte with its flags.
    typedef struct {
        rlbe_pkg::t_byte code;
        logic            ctl;
        logic            last;
        logic            done;
    } t_coded;

    // One directed stimulus row. Rows with n_exp set carry up to two typed-in
    // expected bytes; the others are checked against the predictor.
    typedef struct {
        rlbe_pkg::t_byte data;
        logic            fin;
        int              n_exp;
        rlbe_pkg::t_byte e0;
        logic            c0;
        rlbe_pkg::t_byte e1;
        logic            c1;
    } t_row;

    logic       i_clk;
    logic       i_rst_n      = 1'b0;
    logic       i_valid      = 1'b0;
    logic [7:0] i_data_byte  = 8'h00;
    logic       i_final_byte = 1'b0;
    logic       i_stall      = 1'b0;
    logic       o_stall;
    logic       o_valid;
    logic [7:0] o_out_byte;
    logic       o_is_control;
    logic       o_last_of_item;
    logic       o_stream_done;

    run_length_byte_encoder u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_data_byte    (i_data_byte),
        .i_final_byte   (i_final_byte),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_out_byte     (o_out_byte),
        .o_is_control   (o_is_control),
        .o_last_of_item (o_last_of_item),
        .o_stream_done  (o_stream_done)
    );

    // Encoder state as the predictor sees it.
    rlbe_pkg::t_byte enc_buf [rlbe_pkg::BUF_DEPTH];
    int unsigned     enc_fill   = 0;
    bit              enc_repeat = 1'b0;

    // Bytes produced by the item just predicted, and the store of bytes that
    // the block still owes us, oldest first.
    t_coded item_codes[$];
    t_coded pending_codes[$];

    int n_errors = 0;
    bit calm     = 1'b0;

    // Directed part: extremes of the byte, single-byte streams, runs of two and
    // three, literal groups, and the switches between runs and literals.
    t_row dir_rows [21] = '{
        '{8'h00, 1'b1, 2,         8'd128, 1'b1, 8'h00, 1'b0},
        '{8'hFF, 1'b1, 2,         8'd128, 1'b1, 8'hFF, 1'b0},
        '{8'h5A, 1'b0, PREDICTED, 8'h00,  1'b0, 8'h00, 1'b0},
        '{8'h5A, 1'b1, 2,         8'd2,   1'b1, 8'h5A, 1'b0},
        '{8'h01, 1'b0, PREDICTED, 8'h00,  1'b0, 8'h00, 1'b0},
        '{8'h80, 1'b0, PREDICTED, 8'h00,  1'b0, 8'h00, 1'b0},
        '{8'h7F, 1'b1, PREDICTED, 8'h00,  1'b0, 8'h00, 1'b0},
        '{8'hAA, 1'b0, PREDICTED, 8'h00,  1'b0, 8'h00, 1'b0},
        '{8'hAA, 1'b0, PREDICTED, 8'h00,  1'b0, 8'h00, 1'b0},
        '{8'hAA, 1'b0, PREDICTED, 8'h00,  1'b0, 8'h00, 1'b0},
        '{8'h55, 1'b1, PREDICTED, 8'h00,  1'b0, 8'h00, 1'b0},
        '{8'h11, 1'b0, PREDICTED, 8'h00,  1'b0, 8'h00, 1'b0},
        '{8'h22, 1'b0, PREDICTED, 8'h00,  1'b0, 8'h00, 1'b0},
        '{8'h22, 1'b0, PREDICTED, 8'h00,  1'b0, 8'h00, 1'b0},
        '{8'h22, 1'b1, PREDICTED, 8'h00,  1'b0, 8'h00, 1'b0},
        '{8'hA5, 1'b0, PREDICTED, 8'h00,  1'b0, 8'h00, 1'b0},
        '{8'hC3, 1'b0, PREDICTED, 8'h00,  1'b0, 8'h00, 1'b0},
        '{8'hC3, 1'b1, PREDICTED, 8'h00,  1'b0, 8'h00, 1'b0},
        '{8'hFE, 1'b0, PREDICTED, 8'h00,  1'b0, 8'h00, 1'b0},
        '{8'h01, 1'b0, PREDICTED, 8'h00,  1'b0, 8'h00, 1'b0},
        '{8'hFE, 1'b1, PREDICTED, 8'h00,  1'b0, 8'h00, 1'b0}
    };

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic void push_code(input rlbe_pkg::t_byte value, input logic ctl);
        t_coded c;
        c.code = value;
        c.ctl  = ctl;
        c.last = 1'b0;
        c.done = 1'b0;
        item_codes.push_back(c);
    endfunction

    // A literal group: control byte 127+n, then the first n buffered bytes.
    function automatic void push_literal(input int unsigned n);
        push_code(rlbe_pkg::LIT_BASE + rlbe_pkg::t_byte'(n), 1'b1);
        for (int unsigned i = 0; i < n && i <= rlbe_pkg::MAX_RUN; i++)
            push_code(enc_buf[i], 1'b0);
    endfunction

    // Predictor: takes one input byte, updates the encoder state and leaves
    // the bytes that this item causes in item_codes.
    function automatic void encode_byte(input rlbe_pkg::t_byte b, input logic fin);
        int unsigned     n;
        rlbe_pkg::t_byte newest;
        rlbe_pkg::t_byte older;
        item_codes.delete();
        if (enc_fill <= rlbe_pkg::MAX_RUN) begin
            enc_buf[enc_fill] = b;
            enc_fill++;
        end
        n = enc_fill;
        if (n >= 2 && n <= rlbe_pkg::BUF_DEPTH) begin
            newest = enc_buf[n-1];
            older  = enc_buf[n-2];
            if (enc_repeat) begin
                // A run ends on a different byte or when it grows too long;
                // the newest byte always starts the next group.
                if (newest != older)
                    enc_repeat = 1'b0;
                if (!enc_repeat || n >= rlbe_pkg::MAX_RUN) begin
                    push_code(rlbe_pkg::t_byte'(n - 1), 1'b1);
                    push_code(enc_buf[0], 1'b0);
                    enc_buf[0] = newest;
                    enc_fill   = 1;
                    enc_repeat = 1'b0;
                end
            end else if (newest == older) begin
                // A pair begins a run; the literal bytes before it go out first.
                enc_repeat = 1'b1;
                if (n > 2) begin
                    push_literal(n - 2);
                    enc_buf[0] = newest;
                    enc_buf[1] = newest;
                    enc_fill   = 2;
                end
            end else if (n >= rlbe_pkg::MAX_RUN) begin
                push_literal(n);
                enc_fill = 0;
            end
        end
        if (fin) begin
            // End of stream: whatever is left goes out, possibly nothing.
            n = (enc_fill > rlbe_pkg::BUF_DEPTH) ? rlbe_pkg::BUF_DEPTH : enc_fill;
            if (n != 0) begin
                if (enc_repeat) begin
                    push_code(rlbe_pkg::t_byte'(n), 1'b1);
                    push_code(enc_buf[0], 1'b0);
                end else begin
                    push_literal(n);
                end
            end
            enc_fill   = 0;
            enc_repeat = 1'b0;
        end
        if (item_codes.size() != 0) begin
            item_codes[item_codes.size()-1].last = 1'b1;
            item_codes[item_codes.size()-1].done = fin;
        end
    endfunction

    function automatic void report_mismatch(input string msg);
        n_errors++;
        if (n_errors <= 10)
            $display("mismatch at %0t: %s", $realtime, msg);
    endfunction

    // Compares the output byte taken at this edge with the oldest expectation.
    function automatic void check_code();
        t_coded want;
        if (pending_codes.size() == 0) begin
            report_mismatch($sformatf("unexpected byte %02h ctl=%b last=%b done=%b",
                o_out_byte, o_is_control, o_last_of_item, o_stream_done));
            return;
        end
        want = pending_codes.pop_front();
        if (o_out_byte !== want.code || o_is_control !== want.ctl ||
            o_last_of_item !== want.last || o_stream_done !== want.done) begin
            report_mismatch($sformatf(
                "expected %02h ctl=%b last=%b done=%b, got %02h ctl=%b last=%b done=%b",
                want.code, want.ctl, want.last, want.done,
                o_out_byte, o_is_control, o_last_of_item, o_stream_done));
        end
    endfunction

    // Offers one byte and waits for its transfer. The predictor runs at the
    // edge that takes the byte, so expectations line up with transfer order.
    // A gap lowers valid first; otherwise valid stays high from the previous
    // byte, so it is never lowered and raised within one step.
    task automatic send_byte(input rlbe_pkg::t_byte b, input logic fin,
                             input bit predicted);
        int gap;
        if (!calm && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 5);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_data_byte  <= b;
        i_final_byte <= fin;
        do @(posedge i_clk); while (o_stall);
        encode_byte(b, fin);
        if (predicted) begin
            foreach (item_codes[k])
                pending_codes.push_back(item_codes[k]);
        end
    endtask

    // The sender stops and waits until every expected byte has come out.
    // It always waits on the clock before it checks, so the next raise of valid falls
    // in a later step than this lowering.
    task automatic drain_wait();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending_codes.size() != 0);
    endtask

    // Sender: reset, directed table, then random streams.
    initial begin
        int              n_rand;
        int              len;
        int              k;
        rlbe_pkg::t_byte b;
        rlbe_pkg::t_byte prev;
        logic            fin;
        t_coded          c;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[r]) begin
            if (dir_rows[r].n_exp != PREDICTED) begin
                // Everything before this row has been taken already, so the
                // typed-in bytes queue up behind the earlier expectations.
                for (k = 0; k < dir_rows[r].n_exp; k++) begin
                    c.code = (k == 0) ? dir_rows[r].e0 : dir_rows[r].e1;
                    c.ctl  = (k == 0) ? dir_rows[r].c0 : dir_rows[r].c1;
                    c.last = (k == dir_rows[r].n_exp - 1);
                    c.done = c.last & dir_rows[r].fin;
                    pending_codes.push_back(c);
                end
            end
            send_byte(dir_rows[r].data, dir_rows[r].fin, dir_rows[r].n_exp == PREDICTED);
        end

        // A run longer than the maximum: it is closed at the limit and the
        // newest byte starts the next run, which the final byte flushes.
        b   = rlbe_pkg::t_byte'($urandom_range(0, 255));
        len = $urandom_range(rlbe_pkg::MAX_RUN + 1, rlbe_pkg::MAX_RUN + 6);
        for (k = 0; k < len; k++)
            send_byte(b, k == len - 1, 1'b1);
        n_rand = len;

        drain_wait();

        // A literal group of exactly the maximum, ending the stream: the group
        // closes on the last byte and the flush that follows has nothing left.
        for (k = 0; k < rlbe_pkg::MAX_RUN; k++) begin
            send_byte(b, k == rlbe_pkg::MAX_RUN - 1, 1'b1);
            b = b + rlbe_pkg::t_byte'($urandom_range(1, 255));
        end
        n_rand += rlbe_pkg::MAX_RUN;

        // Short streams mixing runs and literals. Now and then a final flag
        // lands early and breaks a stream off in the middle.
        while (n_rand < RAND_ITEMS) begin
            len  = $urandom_range(1, 12);
            prev = rlbe_pkg::t_byte'($urandom_range(0, 255));
            for (k = 0; k < len; k++) begin
                b   = ($urandom_range(0, 1) != 0) ? prev
                                                  : rlbe_pkg::t_byte'($urandom_range(0, 255));
                fin = (k == len - 1) || ($urandom_range(0, 15) == 0);
                send_byte(b, fin, 1'b1);
                prev = b;
                n_rand++;
                calm = (n_rand >= CALM_AFTER);
            end
        end
        i_valid <= 1'b0;

        while (pending_codes.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (n_errors == 0 && pending_codes.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Receiver: checks each output transfer and drives the stall. Short random
    // stall bursts, plus one long hold-off that lets the block back up into
    // its input while the sender keeps offering bytes.
    initial begin
        int stall_left;
        int n_seen;
        bit held;
        stall_left = 0;
        n_seen     = 0;
        held       = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (o_valid === 1'b1 && i_stall === 1'b0) begin
                check_code();
                n_seen++;
            end
            if (!held && n_seen >= HOLD_AT) begin
                held       = 1'b1;
                stall_left = LONG_HOLD;
            end else if (stall_left == 0 && !calm && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 5);
            end
            if (stall_left > 0) begin
                i_stall <= 1'b1;
                stall_left--;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // Watchdog: a run of cycles with no transfer on either channel means the
    // block has hung.
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
    end

endmodule

[run_length_byte_encoder.f]
rtl/rlbe_pkg.sv
rtl/rlbe_buf_ram.sv
rtl/run_length_byte_encoder.sv
sim/tb.sv
